// ===== rtl/y2r_pkg.sv =====
// Shared types and constants for the YUYV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package y2r_pkg;

  // Line store geometry: one 32-bit YUYV word per column.
  localparam int unsigned MaxLineWidth = 2048;
  localparam int unsigned StoreDepth   = MaxLineWidth / 2;
  localparam int unsigned ColW         = $clog2(StoreDepth);
  localparam int unsigned WordsW       = ColW + 1;

  // Configuration register widths.
  localparam int unsigned LineWidthW   = 12;
  localparam int unsigned FrameHeightW = 11;
  localparam int unsigned AlphaW       = 8;
  localparam int unsigned CfgDataW     = 12;
  localparam int unsigned CfgIndexW    = 2;

  // Configuration reset values.
  localparam logic [LineWidthW-1:0]   LineWidthRst   = LineWidthW'(640);
  localparam logic [FrameHeightW-1:0] FrameHeightRst = FrameHeightW'(480);
  localparam logic [AlphaW-1:0]       AlphaRst       = 8'hFF;

  localparam logic [LineWidthW-1:0] LineWidthMax = LineWidthW'(MaxLineWidth);

  typedef enum logic [CfgIndexW-1:0] {
    CFG_LINE_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_HALF_SIZE    = 2'd2,
    CFG_ALPHA        = 2'd3
  } cfg_index_e;

  // One converted pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Luma plus offset-removed chroma pair handed to the color matrix.
  typedef struct packed {
    logic [7:0]        luma;
    logic signed [8:0] cb;
    logic signed [8:0] cr;
  } ycc_t;

endpackage

`default_nettype wire

// ===== rtl/y2r_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module y2r_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/y2r_color.sv =====
// YCbCr to RGB color matrix with per-channel clamping.
`timescale 1ns / 1ps
`default_nettype none

module y2r_color (
  input  wire y2r_pkg::ycc_t ycc_i,
  output y2r_pkg::rgb_t      rgb_o
);

  import y2r_pkg::*;

  localparam int unsigned SumW = 20;

  localparam logic signed [SumW-1:0] CoefRCr = 20'sd614;
  localparam logic signed [SumW-1:0] CoefGCb = 20'sd77;
  localparam logic signed [SumW-1:0] CoefGCr = 20'sd179;
  localparam logic signed [SumW-1:0] CoefBCb = 20'sd453;

  // Negative clamps to zero, anything at or above 256 * 256 to full scale.
  function automatic logic [7:0] clamp_channel(logic signed [SumW-1:0] s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'd0;
    end else if (|s[SumW-2:16]) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  logic signed [SumW-1:0] y_s;
  logic signed [SumW-1:0] cb_s;
  logic signed [SumW-1:0] cr_s;
  logic signed [SumW-1:0] r_sum;
  logic signed [SumW-1:0] g_sum;
  logic signed [SumW-1:0] b_sum;

  assign y_s  = $signed({4'd0, ycc_i.luma, 8'd0});
  assign cb_s = SumW'(ycc_i.cb);
  assign cr_s = SumW'(ycc_i.cr);

  assign r_sum = y_s + CoefRCr * cr_s;
  assign g_sum = y_s - CoefGCb * cb_s - CoefGCr * cr_s;
  assign b_sum = y_s + CoefBCb * cb_s;

  assign rgb_o.red   = clamp_channel(r_sum);
  assign rgb_o.green = clamp_channel(g_sum);
  assign rgb_o.blue  = clamp_channel(b_sum);

endmodule

`default_nettype wire

// ===== rtl/yuyv_to_rgb_converter.sv =====
// Top level: YUYV 4:2:2 word stream in, RGB pixel stream out.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel (in_valid_i / in_ready_o): one packed YUYV word per beat,
//   raster order. Output channel (out_valid_o / out_ready_i): one pixel per
//   beat as separate bytes plus packed ARGB; last_in_run_o marks the final
//   pixel caused by a word. Config channel (cfg_valid_i / cfg_ready_o) is
//   always ready; write it only while the block is idle.
//   Full mode: each word gives two pixels sharing chroma, so a word occupies
//   the converter stage until both pixels are sent; sustained rate, with a
//   ready receiver, is one pixel per cycle, set by the one-pixel-wide output
//   register. Half-size mode: even-row words go into a 1024 x 32 line store
//   and give no pixel, so they do not occupy the converter stage; odd-row
//   words read their stored partner and give one averaged pixel.
//   An accepted word is registered in the converter stage and its pixels in
//   the output register. A new word is taken in the cycle the previous
//   word's last pixel moves there, so a stalled receiver also holds off input.
//   Receiver stall: the output register holds, the converter stage holds its
//   word, and in_ready_o drops until space frees up. Nothing is dropped.
//   Reset: registers return to 640 x 480, full mode, alpha 0xFF; column and
//   row counters clear. Line store contents are undefined until written;
//   there is no clearing pass.

module yuyv_to_rgb_converter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [y2r_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [y2r_pkg::CfgDataW-1:0]     cfg_data_i,
  // YUYV words
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [7:0]                       luma_first_i,
  input  wire logic [7:0]                       blue_chroma_i,
  input  wire logic [7:0]                       luma_second_i,
  input  wire logic [7:0]                       red_chroma_i,
  // RGB pixels
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [7:0]                            red_o,
  output logic [7:0]                            green_o,
  output logic [7:0]                            blue_o,
  output logic [31:0]                           packed_argb_o,
  output logic                                  last_in_run_o
);

  import y2r_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LineWidthW-1:0]   line_width_q;
  logic [FrameHeightW-1:0] frame_height_q;
  logic                    half_size_q;
  logic [AlphaW-1:0]       alpha_q;
  logic                    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
      half_size_q    <= 1'b0;
      alpha_q        <= AlphaRst;
    end else if (cfg_we) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i[LineWidthW-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FrameHeightW-1:0];
        CFG_HALF_SIZE:    half_size_q    <= cfg_data_i[0];
        CFG_ALPHA:        alpha_q        <= cfg_data_i[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Column / row tracking
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]         col_q, col_d;
  logic [FrameHeightW-1:0] row_q, row_d;
  logic [LineWidthW-1:0]   width_sat;
  logic [WordsW-1:0]       words_raw;
  logic [WordsW-1:0]       words;
  logic [FrameHeightW-1:0] rows;
  logic                    col_last;
  logic                    row_last;
  logic                    in_accept;

  assign width_sat = (line_width_q > LineWidthMax) ? LineWidthMax : line_width_q;
  assign words_raw = width_sat[WordsW:1];
  assign words     = (words_raw == '0) ? WordsW'(1) : words_raw;
  assign rows      = (frame_height_q < FrameHeightW'(2)) ? FrameHeightW'(2) : frame_height_q;

  assign col_last = ({1'b0, col_q} + WordsW'(1)) >= words;
  assign row_last = ({1'b0, row_q} + (FrameHeightW + 1)'(1)) >= {1'b0, rows};

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + FrameHeightW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: even rows write, odd rows read (half-size mode only)
  // ---------------------------------------------------------------------------
  logic        store_we;
  logic        store_re;
  logic [31:0] store_wdata;
  logic [31:0] store_rdata;

  assign store_we    = in_accept & half_size_q & ~row_q[0];
  assign store_re    = in_accept & half_size_q & row_q[0];
  assign store_wdata = {red_chroma_i, luma_second_i, blue_chroma_i, luma_first_i};

  y2r_ram #(
    .Width (32),
    .Depth (StoreDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (col_q),
    .wdata_i (store_wdata),
    .re_i    (store_re),
    .raddr_i (col_q),
    .rdata_o (store_rdata)
  );

  // ---------------------------------------------------------------------------
  // Converter stage: holds one word until all its pixels are handed on.
  // Stored partner word stays on store_rdata until the next read.
  // ---------------------------------------------------------------------------
  logic       s1_valid_q, s1_valid_d;
  logic       s1_half_q;
  logic       s1_idx_q, s1_idx_d;
  logic [7:0] s1_ya_q, s1_cb_q, s1_yb_q, s1_cr_q;
  logic       s1_send;
  logic       s1_last;
  logic       s1_done;
  logic       produces;
  logic       out_load_ok;

  assign produces    = ~half_size_q | row_q[0];
  assign out_load_ok = ~out_valid_o | out_ready_i;
  assign s1_last     = s1_half_q | s1_idx_q;
  assign s1_send     = s1_valid_q & out_load_ok;
  assign s1_done     = s1_send & s1_last;
  assign in_ready_o  = ~s1_valid_q | s1_done;
  assign in_accept   = in_valid_i & in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_idx_d   = s1_idx_q;
    if (in_accept) begin
      s1_valid_d = produces;
      s1_idx_d   = 1'b0;
    end else if (s1_done) begin
      s1_valid_d = 1'b0;
    end else if (s1_send) begin
      s1_idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_idx_q   <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_idx_q   <= s1_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_half_q <= half_size_q;
      s1_ya_q   <= luma_first_i;
      s1_cb_q   <= blue_chroma_i;
      s1_yb_q   <= luma_second_i;
      s1_cr_q   <= red_chroma_i;
    end
  end

  // Half-size: average four lumas, two chromas of each kind.
  logic [9:0] y_sum;
  logic [8:0] cb_sum;
  logic [8:0] cr_sum;
  ycc_t       ycc;
  rgb_t       rgb;

  assign y_sum  = 10'(store_rdata[7:0]) + 10'(store_rdata[23:16])
                + 10'(s1_ya_q) + 10'(s1_yb_q);
  assign cb_sum = 9'(store_rdata[15:8]) + 9'(s1_cb_q);
  assign cr_sum = 9'(store_rdata[31:24]) + 9'(s1_cr_q);

  always_comb begin
    if (s1_half_q) begin
      ycc.luma = y_sum[9:2];
      ycc.cb   = $signed({1'b0, cb_sum[8:1]}) - 9'sd128;
      ycc.cr   = $signed({1'b0, cr_sum[8:1]}) - 9'sd128;
    end else begin
      ycc.luma = s1_idx_q ? s1_yb_q : s1_ya_q;
      ycc.cb   = $signed({1'b0, s1_cb_q}) - 9'sd128;
      ycc.cr   = $signed({1'b0, s1_cr_q}) - 9'sd128;
    end
  end

  y2r_color u_color (
    .ycc_i (ycc),
    .rgb_o (rgb)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_valid_d;
  rgb_t out_rgb_q;
  logic out_last_q;

  always_comb begin
    out_valid_d = out_valid_o;
    if (s1_send) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_send) begin
      out_rgb_q     <= rgb;
      out_last_q    <= s1_last;
      packed_argb_o <= {alpha_q, rgb.red, rgb.green, rgb.blue};
    end
  end

  assign red_o         = out_rgb_q.red;
  assign green_o       = out_rgb_q.green;
  assign blue_o        = out_rgb_q.blue;
  assign last_in_run_o = out_last_q;

endmodule

`default_nettype wire
